// ===== hw/rtl/assert_macros.svh =====
// Concurrent assertion helpers used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");

`endif

// ===== hw/rtl/tscc_pkg.sv =====
package tscc_pkg;

  localparam int unsigned TABLE_DEPTH = 8192;
  localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);
  localparam int unsigned PID_W       = 13;
  localparam int unsigned OUT_CNT_W   = 48;

  localparam logic [7:0]       SYNC_BYTE     = 8'h47;
  localparam logic [7:0]       TEI_BIT       = 8'h80;
  localparam logic [7:0]       PID_HIGH_MASK = 8'h1f;
  localparam logic [PID_W-1:0] NULL_PID      = 13'h1fff;
  localparam logic [7:0]       SCRAMBLE_MASK = 8'hc0;
  localparam logic [7:0]       PAYLOAD_BIT   = 8'h10;
  localparam logic [7:0]       CC_MASK       = 8'h0f;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             err;
    logic             nul;
    logic             chk;
    logic             scr;
    logic             pay;
    logic [3:0]       cc;
  } stage_t;

  typedef struct packed {
    logic                 flag_error;
    logic                 flag_null;
    logic                 flag_scrambled;
    logic                 flag_seq_error;
    logic [OUT_CNT_W-1:0] total_count;
    logic [OUT_CNT_W-1:0] error_count;
    logic [OUT_CNT_W-1:0] seq_error_count;
    logic [OUT_CNT_W-1:0] scrambled_count;
  } result_t;

endpackage

// ===== hw/rtl/ts_continuity_checker_top.sv =====
// Transport stream continuity checker.
// Input channel: the four header bytes of one packet per transfer
// (in_valid_i / in_stall_o). Output channel: one result per input transfer,
// in order (out_valid_o / out_stall_i): four packet flags and four running
// packet counters that include the packet itself.
// An accepted packet is registered in s1_q, its result then in the output
// buffer. Throughput: one packet per cycle while in_stall_o is low. The
// per-PID state sits in one synchronous RAM of {seen, last counter} entries;
// a packet reads its entry when accepted, a checked one writes it back
// next cycle, and a same-PID write by the packet just ahead is forwarded.
// Reset: counters go to zero and the block then sweeps the PID RAM, one
// entry a cycle, marking every PID unseen; in_stall_o stays high until the
// sweep is done.
// Receiver stall: results collect in a two-entry output buffer; once the
// buffer, counting the result in the stage ahead of it, reaches two entries,
// in_stall_o rises in the same cycle, so nothing is dropped.
module ts_continuity_checker_top
  import tscc_pkg::*;
#(
  parameter int unsigned COUNTER_WIDTH = 48
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [7:0]           hdr_byte0_i,
  input  logic [7:0]           hdr_byte1_i,
  input  logic [7:0]           hdr_byte2_i,
  input  logic [7:0]           hdr_byte3_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 flag_error_o,
  output logic                 flag_null_o,
  output logic                 flag_scrambled_o,
  output logic                 flag_seq_error_o,
  output logic [OUT_CNT_W-1:0] total_count_o,
  output logic [OUT_CNT_W-1:0] error_count_o,
  output logic [OUT_CNT_W-1:0] seq_error_count_o,
  output logic [OUT_CNT_W-1:0] scrambled_count_o
);

  localparam int unsigned EXT_W = COUNTER_WIDTH + OUT_CNT_W;
  localparam logic [COUNTER_WIDTH-1:0] CNT_MAX = {COUNTER_WIDTH{1'b1}};
  localparam logic [COUNTER_WIDTH-1:0] CNT_ONE = {{(COUNTER_WIDTH-1){1'b0}}, 1'b1};
  localparam logic [IDX_W-1:0]         IDX_ONE = {{(IDX_W-1){1'b0}}, 1'b1};

  // PID RAM: bit 4 seen, bits 3:0 last continuity counter
  logic [4:0]       mem [TABLE_DEPTH];
  logic [4:0]       rd_q;
  logic             mem_we;
  logic [IDX_W-1:0] mem_wa;
  logic [4:0]       mem_wd;

  logic             clr_q;
  logic [IDX_W-1:0] clr_idx_q;

  stage_t s0;
  stage_t s1_q;
  logic   s1_v_q;

  logic             fwd_v_q;
  logic [IDX_W-1:0] fwd_idx_q;
  logic [3:0]       fwd_cc_q;

  logic [COUNTER_WIDTH-1:0] tot_q, err_q, seq_q, scr_q;
  logic [COUNTER_WIDTH-1:0] tot_d, err_d, seq_d, scr_d;
  logic [EXT_W-1:0]         tot_ext, err_ext, seq_ext, scr_ext;

  result_t    fifo_q [2];
  result_t    res;
  logic       head_q, tail_q;
  logic [1:0] cnt_q;
  logic       push, pop, accept;
  logic [2:0] occ;

  logic [PID_W-1:0] pid;
  logic [4:0]       entry;
  logic [3:0]       expect_cc;
  logic             seq_err;

  // ---- input decode ----
  always_comb begin
    pid    = {hdr_byte1_i[4:0] & PID_HIGH_MASK[4:0], hdr_byte2_i};
    s0.idx = pid[IDX_W-1:0];
    s0.err = (hdr_byte0_i != SYNC_BYTE) || ((hdr_byte1_i & TEI_BIT) != 8'h00);
    s0.nul = !s0.err && (pid == NULL_PID);
    s0.chk = !s0.err && !s0.nul;
    s0.scr = s0.chk && ((hdr_byte3_i & SCRAMBLE_MASK) != 8'h00);
    s0.pay = (hdr_byte3_i & PAYLOAD_BIT) != 8'h00;
    s0.cc  = hdr_byte3_i[3:0] & CC_MASK[3:0];
  end

  // ---- flow control ----
  assign pop    = (cnt_q != 2'd0) && !out_stall_i;
  assign push   = s1_v_q;
  assign occ    = {1'b0, cnt_q} + {2'b00, s1_v_q} - {2'b00, pop};
  assign in_stall_o = clr_q || (occ >= 3'd2);
  assign accept = in_valid_i && !in_stall_o;

  // ---- PID RAM ----
  always_comb begin
    mem_we = clr_q || (s1_v_q && s1_q.chk);
    mem_wa = clr_q ? clr_idx_q : s1_q.idx;
    mem_wd = clr_q ? 5'd0 : {1'b1, s1_q.cc};
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_q <= mem[s0.idx];
  end

  // ---- continuity check ----
  always_comb begin
    entry     = (fwd_v_q && (fwd_idx_q == s1_q.idx)) ? {1'b1, fwd_cc_q} : rd_q;
    expect_cc = s1_q.pay ? entry[3:0] + 4'd1 : entry[3:0];
    seq_err   = s1_q.chk && entry[4] && (s1_q.cc != expect_cc);

    tot_d = tot_q;
    err_d = err_q;
    seq_d = seq_q;
    scr_d = scr_q;
    if (s1_v_q) begin
      if (tot_q != CNT_MAX) tot_d = tot_q + CNT_ONE;
      if (s1_q.err && (err_q != CNT_MAX)) err_d = err_q + CNT_ONE;
      if (seq_err && (seq_q != CNT_MAX)) seq_d = seq_q + CNT_ONE;
      if (s1_q.scr && (scr_q != CNT_MAX)) scr_d = scr_q + CNT_ONE;
    end

    tot_ext = {{OUT_CNT_W{1'b0}}, tot_d};
    err_ext = {{OUT_CNT_W{1'b0}}, err_d};
    seq_ext = {{OUT_CNT_W{1'b0}}, seq_d};
    scr_ext = {{OUT_CNT_W{1'b0}}, scr_d};

    res.flag_error      = s1_q.err;
    res.flag_null       = s1_q.nul;
    res.flag_scrambled  = s1_q.scr;
    res.flag_seq_error  = seq_err;
    res.total_count     = tot_ext[OUT_CNT_W-1:0];
    res.error_count     = err_ext[OUT_CNT_W-1:0];
    res.seq_error_count = seq_ext[OUT_CNT_W-1:0];
    res.scrambled_count = scr_ext[OUT_CNT_W-1:0];
  end

  // ---- control registers ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_idx_q <= '0;
      s1_v_q    <= 1'b0;
      fwd_v_q   <= 1'b0;
      tot_q     <= '0;
      err_q     <= '0;
      seq_q     <= '0;
      scr_q     <= '0;
      head_q    <= 1'b0;
      tail_q    <= 1'b0;
      cnt_q     <= 2'd0;
    end else begin
      if (clr_q) begin
        clr_idx_q <= clr_idx_q + IDX_ONE;
        if (clr_idx_q == {IDX_W{1'b1}}) clr_q <= 1'b0;
      end
      s1_v_q  <= accept;
      fwd_v_q <= s1_v_q && s1_q.chk;
      tot_q   <= tot_d;
      err_q   <= err_d;
      seq_q   <= seq_d;
      scr_q   <= scr_d;
      if (push) tail_q <= ~tail_q;
      if (pop) head_q <= ~head_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  // ---- payload registers ----
  always_ff @(posedge clk_i) begin
    if (accept) s1_q <= s0;
    fwd_idx_q <= s1_q.idx;
    fwd_cc_q  <= s1_q.cc;
    if (push) fifo_q[tail_q] <= res;
  end

  // ---- output ----
  assign out_valid_o       = cnt_q != 2'd0;
  assign flag_error_o      = fifo_q[head_q].flag_error;
  assign flag_null_o       = fifo_q[head_q].flag_null;
  assign flag_scrambled_o  = fifo_q[head_q].flag_scrambled;
  assign flag_seq_error_o  = fifo_q[head_q].flag_seq_error;
  assign total_count_o     = fifo_q[head_q].total_count;
  assign error_count_o     = fifo_q[head_q].error_count;
  assign seq_error_count_o = fifo_q[head_q].seq_error_count;
  assign scrambled_count_o = fifo_q[head_q].scrambled_count;

endmodule

// ===== hw/rtl/tscc_checker.sv =====
`include "assert_macros.svh"

module tscc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        flag_error_o,
  input logic        flag_null_o,
  input logic        flag_scrambled_o,
  input logic        flag_seq_error_o,
  input logic [47:0] total_count_o
);

  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)
  `ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_o && out_stall_i,
               $stable(total_count_o))
  `ASSERT_IMPL(a_err_excl, clk_i, rst_ni, out_valid_o && flag_error_o,
               !flag_null_o && !flag_scrambled_o && !flag_seq_error_o)
  `ASSERT_IMPL(a_null_excl, clk_i, rst_ni, out_valid_o && flag_null_o,
               !flag_scrambled_o && !flag_seq_error_o)

endmodule

bind ts_continuity_checker_top tscc_checker u_tscc_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .flag_error_o     (flag_error_o),
  .flag_null_o      (flag_null_o),
  .flag_scrambled_o (flag_scrambled_o),
  .flag_seq_error_o (flag_seq_error_o),
  .total_count_o    (total_count_o)
);
